@@ src/http_chunked_body_decoder_macros.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Checked on every clock edge, muted while reset is high.
`define HCBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/hcbd_pkg.sv @@
// Types, constants and helpers for the chunked body decoder.
package hcbd_pkg;

   localparam int LENGTH_BITS = 32;

   localparam logic [7:0] CH_CR   = 8'd13;
   localparam logic [7:0] CH_LF   = 8'd10;
   localparam logic [7:0] CH_SEMI = 8'd59;
   localparam logic [7:0] CH_NUL  = 8'd0;

   typedef enum logic [3:0] {
      PH_SIZE       = 4'd0,
      PH_SIZE_LF    = 4'd1,
      PH_DATA       = 4'd2,
      PH_DATA_CR    = 4'd3,
      PH_DATA_LF    = 4'd4,
      PH_TRAILER    = 4'd5,
      PH_TRAILER_LF = 4'd6,
      PH_DONE       = 4'd7,
      PH_ERR1       = 4'd8,
      PH_ERR2       = 4'd9,
      PH_ERR3       = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_SIZE = 2'd1,
      ERR_LINE = 2'd2,
      ERR_TERM = 2'd3
   } err_type;

   typedef struct packed {
      phase_type phase;
      logic      in_extension;
      logic      digit_seen;
      logic      trailer_line_empty;
   } ctl_type;

   typedef struct packed {
      logic [7:0]             payload_byte;
      logic                   payload_valid;
      logic                   body_done;
      err_type                error_code;
      logic [LENGTH_BITS-1:0] body_length;
   } res_type;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_decode(logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c inside {[8'd48:8'd57]}) begin
         d = c - 8'd48;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'd65:8'd70]}) begin
         d = c - 8'd55;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'd97:8'd102]}) begin
         d = c - 8'd87;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

@@ src/hcbd_req_if.sv @@
// Byte request channel: valid, ready and the raw body byte.
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

@@ src/hcbd_rsp_if.sv @@
// Result channel: valid, ready and the decoded fields of one byte.
interface hcbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        body_done;
   logic [1:0]  error_code;
   logic [31:0] body_length;

   modport source (output valid, output payload_byte, output payload_valid,
                   output body_done, output error_code, output body_length,
                   input ready);
   modport sink (input valid, input payload_byte, input payload_valid,
                 input body_done, input error_code, input body_length,
                 output ready);
endinterface

@@ src/hcbd_step.sv @@
// Next-state and result logic for one body byte.
module hcbd_step
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic [7:0]             byte_in,
   input  ctl_type                ctl_cur,
   input  logic [SIZE_BITS-1:0]   size_cur,
   input  logic [SIZE_BITS-1:0]   left_cur,
   input  logic [LENGTH_BITS-1:0] count_cur,
   output ctl_type                ctl_nxt,
   output logic [SIZE_BITS-1:0]   size_nxt,
   output logic [SIZE_BITS-1:0]   left_nxt,
   output logic [LENGTH_BITS-1:0] count_nxt,
   output res_type                res
);

   logic [4:0]           hex;
   logic                 size_full;
   logic [SIZE_BITS-1:0] left_dec;

   assign hex       = hex_decode(byte_in);
   assign size_full = (size_cur[SIZE_BITS-1 -: 4] != 4'd0);
   assign left_dec  = (left_cur != '0) ? left_cur - 1'b1 : left_cur;

   always_comb begin
      ctl_nxt   = ctl_cur;
      size_nxt  = size_cur;
      left_nxt  = left_cur;
      count_nxt = count_cur;

      case (ctl_cur.phase)
         PH_SIZE: begin
            if (byte_in == CH_NUL) begin
               ctl_nxt.phase = PH_ERR1;
            end else if (byte_in == CH_CR) begin
               ctl_nxt.phase = PH_SIZE_LF;
            end else if (ctl_cur.in_extension) begin
               // extension text skipped
            end else if (byte_in == CH_SEMI) begin
               ctl_nxt.in_extension = 1'b1;
            end else if (!hex[4] || size_full) begin
               ctl_nxt.phase = PH_ERR1;
            end else begin
               size_nxt           = {size_cur[SIZE_BITS-5:0], hex[3:0]};
               ctl_nxt.digit_seen = 1'b1;
            end
         end
         PH_SIZE_LF: begin
            if (byte_in != CH_LF) begin
               ctl_nxt.phase = PH_ERR2;
            end else if (!ctl_cur.digit_seen) begin
               ctl_nxt.phase = PH_ERR1;
            end else if (size_cur == '0) begin
               ctl_nxt.phase              = PH_TRAILER;
               ctl_nxt.trailer_line_empty = 1'b1;
            end else begin
               left_nxt      = size_cur;
               ctl_nxt.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (count_cur != '1) begin
               count_nxt = count_cur + 1'b1;
            end
            left_nxt = left_dec;
            if (left_dec == '0) begin
               ctl_nxt.phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            ctl_nxt.phase = (byte_in == CH_CR) ? PH_DATA_LF : PH_ERR3;
         end
         PH_DATA_LF: begin
            if (byte_in == CH_LF) begin
               ctl_nxt.phase        = PH_SIZE;
               ctl_nxt.in_extension = 1'b0;
               ctl_nxt.digit_seen   = 1'b0;
               size_nxt             = '0;
            end else begin
               ctl_nxt.phase = PH_ERR3;
            end
         end
         PH_TRAILER: begin
            if (byte_in == CH_CR) begin
               ctl_nxt.phase = PH_TRAILER_LF;
            end else begin
               ctl_nxt.trailer_line_empty = 1'b0;
            end
         end
         PH_TRAILER_LF: begin
            if (byte_in == CH_LF) begin
               if (ctl_cur.trailer_line_empty) begin
                  ctl_nxt.phase = PH_DONE;
               end else begin
                  ctl_nxt.trailer_line_empty = 1'b1;
                  ctl_nxt.phase              = PH_TRAILER;
               end
            end else begin
               // lone CR was line content; this byte is an ordinary trailer byte
               ctl_nxt.trailer_line_empty = 1'b0;
               ctl_nxt.phase = (byte_in == CH_CR) ? PH_TRAILER_LF : PH_TRAILER;
            end
         end
         default: begin
            // done or error: hold
         end
      endcase
   end

   always_comb begin
      res.payload_valid = (ctl_cur.phase == PH_DATA);
      res.payload_byte  = (ctl_cur.phase == PH_DATA) ? byte_in : 8'd0;
      res.body_done     = (ctl_nxt.phase == PH_DONE);
      res.body_length   = count_nxt;
      case (ctl_nxt.phase)
         PH_ERR1: res.error_code = ERR_SIZE;
         PH_ERR2: res.error_code = ERR_LINE;
         PH_ERR3: res.error_code = ERR_TERM;
         default: res.error_code = ERR_NONE;
      endcase
   end

endmodule

@@ src/http_chunked_body_decoder.sv @@
// A request byte is held in the input register; its result is then registered in
// the result register, from which it can transfer.
// Throughput: one byte per cycle while the result side is not stalled; the parser
// state update from the input register to the result register is combinational and sets that rate.
// The input register can take a new byte while a result waits in the output register.
// Reset (synchronous, active high) empties both registers and returns the parser
// to the start of a size line with a zero body length.
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   hcbd_req_if.sink    req_ch,
   hcbd_rsp_if.source  rsp_ch
);

   // Input register: the byte waiting to be parsed.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Parser state, updated once per byte as it leaves the input register.
   ctl_type                ctl_ff, ctl_in;
   logic [SIZE_BITS-1:0]   size_ff, size_in;
   logic [SIZE_BITS-1:0]   left_ff, left_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   // Result register.
   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   res_type step_res;

   logic req_xfer;
   logic advance;
   logic at_end;

   // A byte moves on when the result register is empty or being drained.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_xfer = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   // Done or any error: the parser stays put from here on.
   assign at_end = (ctl_ff.phase == PH_DONE) || (ctl_ff.phase == PH_ERR1) ||
                   (ctl_ff.phase == PH_ERR2) || (ctl_ff.phase == PH_ERR3);

   hcbd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .byte_in   (in_byte_ff),
      .ctl_cur   (ctl_ff),
      .size_cur  (size_ff),
      .left_cur  (left_ff),
      .count_cur (count_ff),
      .ctl_nxt   (ctl_in),
      .size_nxt  (size_in),
      .left_nxt  (left_in),
      .count_nxt (count_in),
      .res       (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      in_byte_in = req_xfer ? req_ch.data_byte : in_byte_ff;

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      out_in = advance ? step_res : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff.phase              <= PH_SIZE;
         ctl_ff.in_extension       <= 1'b0;
         ctl_ff.digit_seen         <= 1'b0;
         ctl_ff.trailer_line_empty <= 1'b1;
         size_ff  <= '0;
         left_ff  <= '0;
         count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctl_ff   <= ctl_in;
            size_ff  <= size_in;
            left_ff  <= left_in;
            count_ff <= count_in;
         end
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.payload_byte  = out_ff.payload_byte;
   assign rsp_ch.payload_valid = out_ff.payload_valid;
   assign rsp_ch.body_done     = out_ff.body_done;
   assign rsp_ch.error_code    = out_ff.error_code;
   assign rsp_ch.body_length   = out_ff.body_length;

   // Terminal phases never leave without reset.
   `HCBD_ASSERT(a_terminal_hold, at_end |=> $stable(ctl_ff.phase), "terminal phase left")
   // Data phase always has bytes still owed.
   `HCBD_ASSERT(a_data_left, (ctl_ff.phase == PH_DATA) |-> (left_ff != '0), "data phase with nothing left")
   // Body length never falls.
   `HCBD_ASSERT(a_length_mono, advance |=> (count_ff >= $past(count_ff)), "body length fell")
   // A payload byte carries neither done nor an error.
   `HCBD_ASSERT_ALWAYS(a_payload_clean,
      (out_valid_ff && out_ff.payload_valid) |->
         (out_ff.error_code == ERR_NONE && !out_ff.body_done),
      "payload flagged done or error")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the chunked body decoder: chunk streams checked transfer by transfer against a local model.
module tb_top;
   import hcbd_pkg::*;

   localparam int SZ_BITS     = 32;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_BYTES = 200;   // four random-traffic phases, roughly 800 bytes in all

   // How the body is brought to an end. Done and every error are terminal and reset
   // is applied only once, so each run closes on exactly one of these.
   typedef enum int {
      END_DONE,
      END_NUL_SIZE,
      END_NUL_EXT,
      END_NON_HEX,
      END_OVERFLOW,
      END_BAD_LF,
      END_EMPTY,
      END_BAD_TERM_CR,
      END_BAD_TERM_LF
   } ending_type;

   logic clock;
   logic reset;

   hcbd_req_if req_ch();
   hcbd_rsp_if rsp_ch();

   http_chunked_body_decoder #(.SIZE_BITS(SZ_BITS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------------------
   // Parser model state, reset values as after the one reset of the run
   // ---------------------------------------------------------------------------
   phase_type   cur_phase     = PH_SIZE;
   logic [31:0] size_sum      = '0;
   logic [31:0] remaining     = '0;
   logic        in_ext        = 1'b0;
   logic        saw_digit     = 1'b0;
   logic        trailer_blank = 1'b1;
   logic [31:0] length_count  = '0;

   res_type pending_decodes[$];   // one expected result per accepted byte, oldest first
   int      mismatch_count = 0;
   int      bytes_sent     = 0;
   int      idle_pct       = 0;   // chance per cycle that the sender holds off
   int      stall_pct      = 0;   // chance per cycle that the receiver holds off

   // Advance the parser model by one body byte and return what the block should report.
   function automatic res_type decode_byte(input logic [7:0] c);
      res_type    r;
      logic [4:0] nib;   // {is hex digit, digit value}
      r   = '0;
      nib = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)
         nib = {1'b1, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         nib = {1'b1, c[3:0] + 4'd9};

      case (cur_phase)
         PH_SIZE: begin
            if (c == CH_NUL) begin
               cur_phase = PH_ERR1;               // NUL is fatal even inside an extension
            end else if (c == CH_CR) begin
               cur_phase = PH_SIZE_LF;
            end else if (!in_ext) begin
               if (c == CH_SEMI) begin
                  in_ext = 1'b1;                  // rest of the line is ignored
               end else if (!nib[4] || (size_sum >> (SZ_BITS - 4)) != 0) begin
                  cur_phase = PH_ERR1;            // junk, or this digit would overflow
               end else begin
                  size_sum  = {size_sum[27:0], nib[3:0]};
                  saw_digit = 1'b1;
               end
            end
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               cur_phase = PH_ERR2;
            end else if (!saw_digit) begin
               cur_phase = PH_ERR1;               // empty size only shows at the LF
            end else if (size_sum == 0) begin
               cur_phase     = PH_TRAILER;
               trailer_blank = 1'b1;
            end else begin
               remaining = size_sum;
               cur_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.payload_byte  = c;
            r.payload_valid = 1'b1;
            if (length_count != '1)
               length_count++;
            if (remaining != 0)
               remaining--;
            if (remaining == 0)
               cur_phase = PH_DATA_CR;
         end
         PH_DATA_CR: cur_phase = (c == CH_CR) ? PH_DATA_LF : PH_ERR3;
         PH_DATA_LF: begin
            if (c == CH_LF) begin
               cur_phase = PH_SIZE;
               size_sum  = '0;
               in_ext    = 1'b0;
               saw_digit = 1'b0;
            end else begin
               cur_phase = PH_ERR3;
            end
         end
         PH_TRAILER: begin
            if (c == CH_CR)
               cur_phase = PH_TRAILER_LF;
            else
               trailer_blank = 1'b0;
         end
         PH_TRAILER_LF: begin
            if (c == CH_LF) begin
               if (trailer_blank) begin
                  cur_phase = PH_DONE;
               end else begin
                  trailer_blank = 1'b1;
                  cur_phase     = PH_TRAILER;
               end
            end else begin
               // lone CR was line content; this byte is an ordinary trailer byte
               trailer_blank = 1'b0;
               cur_phase     = (c == CH_CR) ? PH_TRAILER_LF : PH_TRAILER;
            end
         end
         default: ;   // done or error: byte is dropped, outputs repeat
      endcase

      r.body_done   = (cur_phase == PH_DONE);
      r.error_code  = (cur_phase == PH_ERR1) ? ERR_SIZE :
                      (cur_phase == PH_ERR2) ? ERR_LINE :
                      (cur_phase == PH_ERR3) ? ERR_TERM : ERR_NONE;
      r.body_length = length_count;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // One request transfer, with random hold-off before it. valid is left high after
   // the transfer; the next call or the end of the run decides what it does next.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      pending_decodes.push_back(decode_byte(b));
      bytes_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
      if (v < 4'd10)
         return 8'h30 + v;
      return (upper ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   task automatic send_crlf();
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // Hex size, most significant digit first, digit case picked at random
   task automatic send_digits(input logic [31:0] v, input int lead_zeros);
      int n;
      n = 1;
      while (n < 8 && (v >> (4 * n)) != 0)
         n++;
      repeat (lead_zeros) send_byte(8'h30);
      for (int i = n - 1; i >= 0; i--)
         send_byte(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
   endtask

   // ';' then a few arbitrary bytes; anything goes except NUL and CR
   task automatic send_extension();
      logic [7:0] b;
      send_byte(CH_SEMI);
      repeat ($urandom_range(0, 6)) begin
         do
            b = 8'($urandom_range(1, 255));
         while (b == CH_CR);
         send_byte(b);
      end
   endtask

   task automatic send_size_line(input logic [31:0] size, input int lead_zeros,
                                 input bit with_ext);
      send_digits(size, lead_zeros);
      if (with_ext)
         send_extension();
      send_crlf();
   endtask

   task automatic send_random_chunk(input int size);
      send_size_line(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                     $urandom_range(0, 3) == 0);
      repeat (size) send_byte(8'($urandom_range(0, 255)));
      send_crlf();
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Payload extremes, leading zeros and an extension holding awkward bytes
   task automatic test_directed_chunks();
      send_size_line(1, 0, 1'b0);
      send_byte(8'h00);
      send_crlf();

      send_size_line(1, 3, 1'b0);
      send_byte(8'hFF);
      send_crlf();

      // extension with 0xFF, a bare LF and a second ';' - all skipped
      send_digits(2, 0);
      send_byte(CH_SEMI);
      send_byte(8'hFF);
      send_byte(CH_LF);
      send_byte(CH_SEMI);
      send_byte(8'h20);
      send_crlf();
      send_byte(8'h55);
      send_byte(8'hAA);
      send_crlf();
   endtask

   // Well-formed chunks with random content; mostly short, now and then a longer one
   task automatic test_random_chunks(input int idle, input int stall, input int budget);
      int target;
      idle_pct  = idle;
      stall_pct = stall;
      target    = bytes_sent + budget;
      while (bytes_sent < target)
         send_random_chunk(($urandom_range(0, 19) == 0) ? $urandom_range(64, 200)
                                                        : $urandom_range(1, 24));
   endtask

   // Close the body, either cleanly through the trailer or through one error
   task automatic test_body_end(input ending_type kind);
      logic [7:0] b;
      int         n;
      case (kind)
         END_DONE: begin
            send_size_line(0, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 3)) begin
               repeat ($urandom_range(1, 8)) begin
                  b = 8'($urandom_range(0, 255));   // NUL is fine in a trailer
                  send_byte((b == CH_CR) ? CH_NUL : b);
               end
               if ($urandom_range(0, 1)) begin
                  send_byte(CH_CR);                 // CR without LF stays line content
                  send_byte(8'h78);
               end
               send_crlf();
            end
            send_crlf();                            // blank line ends the body
         end
         END_NUL_SIZE: begin
            send_digits($urandom_range(1, 255), 0);
            send_byte(CH_NUL);
         end
         END_NUL_EXT: begin
            send_digits(5, 0);
            send_byte(CH_SEMI);
            send_byte(8'h61);
            send_byte(CH_NUL);
         end
         END_NON_HEX: begin
            send_digits($urandom_range(1, 4095), 0);
            do
               b = 8'($urandom_range(1, 255));
            while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                   (b >= 8'h61 && b <= 8'h66) || b == CH_CR || b == CH_SEMI);
            send_byte(b);
         end
         END_OVERFLOW: begin
            // eight significant digits, leading zeros not counted, then one too many
            send_digits(32'h1000_0000 | $urandom, $urandom_range(0, 3));
            send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
         end
         END_BAD_LF: begin
            send_digits(3, 0);
            send_byte(CH_CR);
            do
               b = 8'($urandom_range(0, 255));
            while (b == CH_LF);
            send_byte(b);
         end
         END_EMPTY: begin
            if ($urandom_range(0, 1))
               send_extension();
            send_crlf();
         end
         END_BAD_TERM_CR, END_BAD_TERM_LF: begin
            n = $urandom_range(1, 8);
            send_size_line(n, 0, 1'b0);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
            if (kind == END_BAD_TERM_LF) begin
               send_byte(CH_CR);
               do
                  b = 8'($urandom_range(0, 255));
               while (b == CH_LF);
            end else begin
               do
                  b = 8'($urandom_range(0, 255));
               while (b == CH_CR);
            end
            send_byte(b);
         end
         default: ;
      endcase
   endtask

   // Bytes after the end must be swallowed with the final status repeated
   task automatic test_after_end();
      repeat (8) send_byte(8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure and the transfer checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : check_results
      res_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_decodes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result transfer with nothing expected (byte %02h len %0d)",
                        $time, rsp_ch.payload_byte, rsp_ch.body_length);
         end else begin
            want = pending_decodes.pop_front();
            if (rsp_ch.payload_byte  !== want.payload_byte  ||
                rsp_ch.payload_valid !== want.payload_valid ||
                rsp_ch.body_done     !== want.body_done     ||
                rsp_ch.error_code    !== want.error_code    ||
                rsp_ch.body_length   !== want.body_length) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: mismatch byte/valid/done/err/len",
                            " expected %02h/%0d/%0d/%0d/%0d got %02h/%0d/%0d/%0d/%0d"},
                           $time, want.payload_byte, want.payload_valid, want.body_done,
                           want.error_code, want.body_length, rsp_ch.payload_byte,
                           rsp_ch.payload_valid, rsp_ch.body_done, rsp_ch.error_code,
                           rsp_ch.body_length);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      int         pick;
      ending_type finale;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_chunks();
      test_random_chunks(0, 0, PHASE_BYTES);
      test_random_chunks(58, 0, PHASE_BYTES);
      test_random_chunks(0, 58, PHASE_BYTES);
      test_random_chunks(33, 33, PHASE_BYTES);

      // clean finish in half of all runs, each error ending 1 in 16
      pick   = $urandom_range(0, 15);
      finale = (pick > int'(END_BAD_TERM_LF)) ? END_DONE : ending_type'(pick);
      test_body_end(finale);
      test_after_end();
      req_ch.valid <= 1'b0;

      // drain, then give the two-stage pipe time to show any stray transfer
      while (pending_decodes.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_decodes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/hcbd_pkg.sv
src/hcbd_req_if.sv
src/hcbd_rsp_if.sv
src/hcbd_step.sv
src/http_chunked_body_decoder.sv
tb/tb_top.sv
